FILE: rtl/rcsfr_pkg.sv
// Shared types and constants of the RC serial frame receiver.
package rcsfr_pkg;

    localparam int FRAME_DATA_BYTES_DEF = 30;
    localparam int CHANNELS_DEF         = 14;

    localparam int BYTE_W   = 8;
    localparam int VALUE_W  = 16;
    localparam int INDEX_W  = 4;
    localparam int POS_W    = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [VALUE_W-1:0] CSUM_INIT      = 16'hFFFF;
    localparam logic [VALUE_W-1:0] SILENCE_MAX    = 16'hFFFF;
    localparam logic [BYTE_W-1:0]  SYNC_FIRST_RST  = 8'd32;
    localparam logic [BYTE_W-1:0]  SYNC_SECOND_RST = 8'd64;
    localparam logic [VALUE_W-1:0] DEAD_TIME_RST   = 16'd500;
    localparam logic [VALUE_W-1:0] DEFAULT_VAL_RST = 16'd1500;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_TICK = 2'd1,
        KIND_READ = 2'd2,
        KIND_NONE = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_FIRST  = 2'd0,
        CFG_SYNC_SECOND = 2'd1,
        CFG_DEAD_TIME   = 2'd2,
        CFG_DEFAULT_VAL = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        kind_t               kind;
        logic [BYTE_W-1:0]   rx_byte;
        logic [INDEX_W-1:0]  channel_index;
    } in_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  channel_value;
        logic                failsafe;
        logic                frame_ok;
        logic                checksum_error;
    } out_item_t;

    // Write side of the result buffer.
    typedef struct packed {
        logic      push;
        out_item_t item;
    } buf_wr_t;

endpackage

FILE: rtl/rcsfr_chan_if.sv
// Valid/ready channel interface that carries one item per handshake.
interface rcsfr_chan_if #(
    parameter type payload_t = rcsfr_pkg::in_item_t
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/rcsfr_out_buf.sv
// Two-entry result buffer that decouples the decoder from the result consumer.
module rcsfr_out_buf (
    input  logic               clk,
    input  logic               rst_n,
    input  rcsfr_pkg::buf_wr_t wr,
    output logic               full,
    rcsfr_chan_if.source       out_ch
);

    rcsfr_pkg::out_item_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign pop            = out_ch.valid && out_ch.ready;
    assign full           = (count_reg == 2'd2);
    assign out_ch.valid   = (count_reg != 2'd0);
    assign out_ch.payload = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ wr.push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, wr.push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.push)
        begin
            entry_reg[wr_ptr_reg] <= wr.item;
        end
    end

endmodule

FILE: rtl/rc_serial_frame_receiver.sv
// Top level of the RC serial frame receiver: sync hunt, payload capture, checksum, failsafe.
// Throughput: one item per clock cycle, sustained, as long as results are taken.
// A result is written into the result buffer when its item is accepted and offered from there.
// A two-entry result buffer lets input continue while a result waits; ready drops only
// when both entries hold untaken results.
// Reset: asynchronous, active low; state registers take documented values, failsafe set.
module rc_serial_frame_receiver #(
    parameter int FRAME_DATA_BYTES = rcsfr_pkg::FRAME_DATA_BYTES_DEF,
    parameter int CHANNELS         = rcsfr_pkg::CHANNELS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    rcsfr_chan_if.sink                          in_ch,
    rcsfr_chan_if.source                        out_ch,
    input  logic                                cfg_we,
    input  logic [rcsfr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rcsfr_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int POS_W    = rcsfr_pkg::POS_W;
    localparam int SLOT_W   = POS_W - 1;
    localparam int VALUE_W  = rcsfr_pkg::VALUE_W;
    localparam int BYTE_W   = rcsfr_pkg::BYTE_W;
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    // Number of channels that one frame carries; an odd trailing byte only feeds the checksum.
    localparam int FRAME_CH = (FRAME_DATA_BYTES - 2) / 2;

    // Parser phases: hunting for the two sync bytes, collecting payload,
    // then the low and high checksum bytes.
    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_CK_LO   = 2'd2,
        PH_CK_HI   = 2'd3
    } phase_t;

    // Configuration registers.
    logic [BYTE_W-1:0]  sync_first_reg;
    logic [BYTE_W-1:0]  sync_second_reg;
    logic [VALUE_W-1:0] dead_time_reg;
    logic [VALUE_W-1:0] default_val_reg;

    // Parser and link state.
    phase_t             phase_reg, phase_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [VALUE_W-1:0] csum_reg, csum_next;
    logic [BYTE_W-1:0]  ck_lo_reg, ck_lo_next;
    logic [VALUE_W-1:0] silence_reg, silence_next;
    logic               failsafe_reg, failsafe_next;

    // Channel storage: pending is filled by the current frame, live holds committed values.
    logic [VALUE_W-1:0] pending_reg [CHANNELS];
    logic [VALUE_W-1:0] live_reg [CHANNELS];

    rcsfr_pkg::in_item_t  item;
    rcsfr_pkg::buf_wr_t   buf_wr;
    logic                 buf_full;
    logic                 accept;

    logic [POS_W-1:0]     pay_k;
    logic [SLOT_W-1:0]    slot;
    logic [CH_IDX_W-1:0]  slot_idx;
    logic [CH_IDX_W-1:0]  rd_idx;
    logic                 pend_we;
    logic                 commit;
    logic                 fill;
    logic [VALUE_W-1:0]   silence_inc;
    logic [VALUE_W-1:0]   got_csum;

    assign item        = in_ch.payload;
    assign in_ch.ready = !buf_full;
    assign accept      = in_ch.valid && in_ch.ready;

    // The payload byte position k = pos - 2 picks the channel slot (k / 2)
    // and which half of it the byte lands in (k odd means high byte).
    assign pay_k    = pos_reg - POS_W'(2);
    assign slot     = pay_k[POS_W-1:1];
    assign slot_idx = slot[CH_IDX_W-1:0];
    assign rd_idx   = item.channel_index[CH_IDX_W-1:0];
    assign got_csum = {item.rx_byte, ck_lo_reg};
    assign silence_inc = (silence_reg == rcsfr_pkg::SILENCE_MAX) ? silence_reg
                                                                 : silence_reg + 16'd1;

    // Next state and result for the item at the input; everything below applies
    // only on an accepted handshake.
    always_comb
    begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        csum_next     = csum_reg;
        ck_lo_next    = ck_lo_reg;
        silence_next  = silence_reg;
        failsafe_next = failsafe_reg;
        pend_we       = 1'b0;
        commit        = 1'b0;
        fill          = 1'b0;
        buf_wr.push                = accept;
        buf_wr.item.channel_value  = '0;
        buf_wr.item.frame_ok       = 1'b0;
        buf_wr.item.checksum_error = 1'b0;

        if (accept)
        begin
            unique case (item.kind)
                rcsfr_pkg::KIND_BYTE:
                begin
                    unique case (phase_reg)
                        PH_HUNT:
                        begin
                            // When both sync values are equal, the second position wins.
                            // A repeated first sync byte restarts the match.
                            if (pos_reg == POS_W'(1) && item.rx_byte == sync_second_reg)
                            begin
                                csum_next  = csum_reg - {8'h00, item.rx_byte};
                                pos_next   = POS_W'(2);
                                phase_next = PH_PAYLOAD;
                            end
                            else if (item.rx_byte == sync_first_reg)
                            begin
                                csum_next = rcsfr_pkg::CSUM_INIT - {8'h00, item.rx_byte};
                                pos_next  = POS_W'(1);
                            end
                            else
                            begin
                                csum_next = rcsfr_pkg::CSUM_INIT;
                                pos_next  = '0;
                            end
                        end
                        PH_PAYLOAD:
                        begin
                            csum_next = csum_reg - {8'h00, item.rx_byte};
                            pend_we   = (slot < SLOT_W'(CHANNELS));
                            pos_next  = pos_reg + POS_W'(1);
                            if (pos_next >= POS_W'(FRAME_DATA_BYTES))
                            begin
                                phase_next = PH_CK_LO;
                            end
                        end
                        PH_CK_LO:
                        begin
                            ck_lo_next = item.rx_byte;
                            phase_next = PH_CK_HI;
                        end
                        PH_CK_HI:
                        begin
                            // The frame ends here either way; a match commits the channels.
                            if (got_csum == csum_reg)
                            begin
                                commit        = 1'b1;
                                silence_next  = '0;
                                failsafe_next = 1'b0;
                                buf_wr.item.frame_ok = 1'b1;
                            end
                            else
                            begin
                                buf_wr.item.checksum_error = 1'b1;
                            end
                            phase_next = PH_HUNT;
                            pos_next   = '0;
                            csum_next  = rcsfr_pkg::CSUM_INIT;
                        end
                        default:
                        begin
                            phase_next = PH_HUNT;
                        end
                    endcase
                end
                rcsfr_pkg::KIND_TICK:
                begin
                    // Each tick re-evaluates failsafe against the current dead time.
                    silence_next  = silence_inc;
                    failsafe_next = (silence_inc > dead_time_reg);
                    fill          = failsafe_next;
                end
                rcsfr_pkg::KIND_READ:
                begin
                    // Out-of-range reads return zero, even in failsafe.
                    if ({1'b0, item.channel_index} < (rcsfr_pkg::INDEX_W + 1)'(CHANNELS))
                    begin
                        buf_wr.item.channel_value = failsafe_reg ? default_val_reg
                                                                 : live_reg[rd_idx];
                    end
                end
                rcsfr_pkg::KIND_NONE:
                begin
                end
                default:
                begin
                end
            endcase
        end
        buf_wr.item.failsafe = failsafe_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= rcsfr_pkg::SYNC_FIRST_RST;
            sync_second_reg <= rcsfr_pkg::SYNC_SECOND_RST;
            dead_time_reg   <= rcsfr_pkg::DEAD_TIME_RST;
            default_val_reg <= rcsfr_pkg::DEFAULT_VAL_RST;
            phase_reg       <= PH_HUNT;
            pos_reg         <= '0;
            csum_reg        <= rcsfr_pkg::CSUM_INIT;
            ck_lo_reg       <= '0;
            silence_reg     <= '0;
            failsafe_reg    <= 1'b1;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (rcsfr_pkg::cfg_reg_t'(cfg_index))
                    rcsfr_pkg::CFG_SYNC_FIRST:  sync_first_reg  <= cfg_data[BYTE_W-1:0];
                    rcsfr_pkg::CFG_SYNC_SECOND: sync_second_reg <= cfg_data[BYTE_W-1:0];
                    rcsfr_pkg::CFG_DEAD_TIME:   dead_time_reg   <= cfg_data[VALUE_W-1:0];
                    rcsfr_pkg::CFG_DEFAULT_VAL: default_val_reg <= cfg_data[VALUE_W-1:0];
                    default:                    dead_time_reg   <= dead_time_reg;
                endcase
            end
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            csum_reg     <= csum_next;
            ck_lo_reg    <= ck_lo_next;
            silence_reg  <= silence_next;
            failsafe_reg <= failsafe_next;
        end
    end

    // Pending channels: the low byte clears the upper half, the high byte is merged in.
    always_ff @(posedge clk)
    begin
        if (pend_we)
        begin
            if (!pay_k[0])
            begin
                pending_reg[slot_idx] <= {8'h00, item.rx_byte};
            end
            else
            begin
                pending_reg[slot_idx] <= pending_reg[slot_idx] | {item.rx_byte, 8'h00};
            end
        end
    end

    // Live channels: filled with the default on a failsafe tick, loaded from pending on a
    // good frame. Channels beyond the frame's channel count keep their values.
    for (genvar g = 0; g < CHANNELS; g++)
    begin : g_live
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                live_reg[g] <= rcsfr_pkg::DEFAULT_VAL_RST;
            end
            else if (fill)
            begin
                live_reg[g] <= default_val_reg;
            end
            else if (commit && (g < FRAME_CH))
            begin
                live_reg[g] <= pending_reg[g];
            end
        end
    end

    rcsfr_out_buf u_out_buf (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (buf_wr),
        .full   (buf_full),
        .out_ch (out_ch)
    );

endmodule

FILE: rtl/rcsfr_checker.sv
// Port-level assertions for the RC serial frame receiver, bound to the top level.
module rcsfr_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_failsafe,
    input logic out_frame_ok,
    input logic out_checksum_error
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn before it was taken");

    a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && in_valid && in_ready |=> out_valid)
        else $error("result not offered one cycle after an accepted item");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result waiting");

    a_frame_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_frame_ok && out_checksum_error))
        else $error("frame reported both good and bad");

    a_good_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_frame_ok |-> !out_failsafe)
        else $error("good frame left failsafe set");

endmodule

bind rc_serial_frame_receiver rcsfr_checker u_rcsfr_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_ch.valid),
    .in_ready           (in_ch.ready),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_failsafe       (out_ch.payload.failsafe),
    .out_frame_ok       (out_ch.payload.frame_ok),
    .out_checksum_error (out_ch.payload.checksum_error)
);

FILE: bench/tb_rc_serial_frame_receiver.sv
// Self-checking testbench of the RC serial frame receiver with its own frame decoder model.
module tb_rc_serial_frame_receiver;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_BYTES    = rcsfr_pkg::FRAME_DATA_BYTES_DEF;
    localparam int NUM_CH         = rcsfr_pkg::CHANNELS_DEF;
    localparam int FRAME_CHANNELS = (FRAME_BYTES - 2) / 2;
    localparam int PHASE_ITEMS    = 200;
    localparam int SATURATE_TICKS = 65540;
    // The limit leaves room for the slowest correct run: the long tick run goes without idling,
    // and every other item may see a full sender gap plus a full receiver stall.
    localparam int CYCLE_LIMIT    = 400000;

    // Progress of the frame parser in the model.
    typedef enum logic [1:0] {
        PARSE_HUNT,
        PARSE_PAYLOAD,
        PARSE_CK_LO,
        PARSE_CK_HI
    } parse_phase_t;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_we;
    logic [rcsfr_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [rcsfr_pkg::CFG_DATA_W-1:0] cfg_data;

    rcsfr_chan_if #(.payload_t(rcsfr_pkg::in_item_t))  in_ch ();
    rcsfr_chan_if #(.payload_t(rcsfr_pkg::out_item_t)) out_ch ();

    rc_serial_frame_receiver i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Register copies as the block should hold them.
    logic [7:0]  cur_sync_first;
    logic [7:0]  cur_sync_second;
    logic [15:0] cur_dead_time;
    logic [15:0] cur_default;

    // Decoder state as the block should hold it.
    parse_phase_t                parse_state;
    logic [rcsfr_pkg::POS_W-1:0] pos;
    logic [15:0]                 csum_acc;
    logic [7:0]                  csum_lo;
    logic [15:0]                 pend_ch [NUM_CH];
    logic [15:0]                 live_ch [NUM_CH];
    logic [15:0]                 quiet_ticks;
    logic                        in_failsafe;

    // Decoded results in the order that the block must deliver them.
    rcsfr_pkg::out_item_t decoded_q [$];

    int  error_count = 0;
    int  items_sent  = 0;
    int  cycle_count = 0;
    // When set, neither side inserts idle cycles.
    bit  no_idle     = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------

    function automatic void restart_hunt();
        parse_state = PARSE_HUNT;
        pos         = '0;
        csum_acc    = rcsfr_pkg::CSUM_INIT;
    endfunction

    // Applies one item to the model state and returns the result that the block owes for it.
    function automatic rcsfr_pkg::out_item_t decode_step(rcsfr_pkg::in_item_t it);
        rcsfr_pkg::out_item_t r;
        int                   k;
        int                   slot;
        logic [7:0]           b;
        logic [15:0]          got;
        r = '0;
        b = it.rx_byte;
        case (it.kind)
            rcsfr_pkg::KIND_BYTE:
            begin
                case (parse_state)
                    PARSE_HUNT:
                    begin
                        // The second sync check comes first, so equal sync values still
                        // advance; a repeated first sync byte simply restarts the match.
                        if (pos == 1 && b == cur_sync_second)
                        begin
                            csum_acc    = csum_acc - b;
                            pos         = 2;
                            parse_state = PARSE_PAYLOAD;
                        end
                        else if (b == cur_sync_first)
                        begin
                            csum_acc = rcsfr_pkg::CSUM_INIT - b;
                            pos      = 1;
                        end
                        else
                        begin
                            restart_hunt();
                        end
                    end
                    PARSE_PAYLOAD:
                    begin
                        csum_acc = csum_acc - b;
                        k        = int'(pos) - 2;
                        slot     = k / 2;
                        // Payload pairs past the last channel only feed the checksum.
                        if (slot < NUM_CH)
                        begin
                            if (k % 2 == 0)
                                pend_ch[slot] = {8'h00, b};
                            else
                                pend_ch[slot] = pend_ch[slot] | {b, 8'h00};
                        end
                        pos = pos + 1'b1;
                        if (pos >= FRAME_BYTES)
                            parse_state = PARSE_CK_LO;
                    end
                    PARSE_CK_LO:
                    begin
                        csum_lo     = b;
                        parse_state = PARSE_CK_HI;
                    end
                    default:
                    begin
                        got = {b, csum_lo};
                        if (got == csum_acc)
                        begin
                            for (k = 0; k < FRAME_CHANNELS && k < NUM_CH; k++)
                                live_ch[k] = pend_ch[k];
                            quiet_ticks = '0;
                            in_failsafe = 1'b0;
                            r.frame_ok  = 1'b1;
                        end
                        else
                        begin
                            r.checksum_error = 1'b1;
                        end
                        restart_hunt();
                    end
                endcase
            end
            rcsfr_pkg::KIND_TICK:
            begin
                if (quiet_ticks != rcsfr_pkg::SILENCE_MAX)
                    quiet_ticks = quiet_ticks + 1'b1;
                in_failsafe = (quiet_ticks > cur_dead_time);
                if (in_failsafe)
                begin
                    for (k = 0; k < NUM_CH; k++)
                        live_ch[k] = cur_default;
                end
            end
            rcsfr_pkg::KIND_READ:
            begin
                if (it.channel_index < NUM_CH)
                    r.channel_value = in_failsafe ? cur_default : live_ch[it.channel_index];
            end
            default:
            begin
            end
        endcase
        r.failsafe = in_failsafe;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Every result that the block hands over is matched against the oldest decoded result.
    // Sampling at the clock edge sees the values from before the edge, since both sides
    // update their signals with nonblocking assignments.
    always @(posedge clk)
    begin : result_check
        rcsfr_pkg::out_item_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (decoded_q.size() == 0)
            begin
                $display("%0t: result with nothing expected, expected none, actual %h",
                         $time, out_ch.payload);
                error_count++;
            end
            else
            begin
                want = decoded_q.pop_front();
                check_field("channel_value", want.channel_value, out_ch.payload.channel_value);
                check_field("failsafe", want.failsafe, out_ch.payload.failsafe);
                check_field("frame_ok", want.frame_ok, out_ch.payload.frame_ok);
                check_field("checksum_error", want.checksum_error,
                            out_ch.payload.checksum_error);
            end
        end
    end

    // The result side takes results in random runs, broken by stalls of random length unless no_idle is set.
    initial
    begin : result_taker
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clk);
            if (!no_idle && $urandom_range(0, 1) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    // The run ends with a failure if it has not finished within the cycle limit.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: cycle limit reached with %0d results outstanding",
                 $time, decoded_q.size());
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Item sending
    // ------------------------------------------------------------------

    // Offers one item, sometimes after an idle gap, and records its decoded result once the
    // block has accepted it. It returns at the accepting edge with valid still high, so a
    // following item goes out back to back.
    task automatic send_item(rcsfr_pkg::in_item_t it);
        if (!no_idle && $urandom_range(0, 5) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= it;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        decoded_q.push_back(decode_step(it));
        if (it.kind != rcsfr_pkg::KIND_NONE)
            items_sent++;
    endtask

    task automatic send_byte(logic [7:0] b);
        rcsfr_pkg::in_item_t it;
        it.kind          = rcsfr_pkg::KIND_BYTE;
        it.rx_byte       = b;
        it.channel_index = 4'($urandom_range(0, 15));
        send_item(it);
    endtask

    task automatic send_tick();
        rcsfr_pkg::in_item_t it;
        it.kind          = rcsfr_pkg::KIND_TICK;
        it.rx_byte       = 8'($urandom_range(0, 255));
        it.channel_index = 4'($urandom_range(0, 15));
        send_item(it);
    endtask

    task automatic send_read(logic [3:0] idx);
        rcsfr_pkg::in_item_t it;
        it.kind          = rcsfr_pkg::KIND_READ;
        it.rx_byte       = 8'($urandom_range(0, 255));
        it.channel_index = idx;
        send_item(it);
    endtask

    task automatic send_none();
        rcsfr_pkg::in_item_t it;
        it.kind          = rcsfr_pkg::KIND_NONE;
        it.rx_byte       = 8'($urandom_range(0, 255));
        it.channel_index = 4'($urandom_range(0, 15));
        send_item(it);
    endtask

    // Sends a frame under the current sync values. The frame can be cut short, carry a
    // wrong checksum or a wrong second sync byte, use alternating all-zero and all-one
    // channels, and have ticks and reads mixed in between its bytes.
    task automatic send_frame(int n_bytes, bit corrupt, bit extremes, bit chatter,
                              bit bad_sync);
        logic [7:0]  fb [FRAME_BYTES + 2];
        logic [15:0] sum;
        int          i;
        fb[0] = cur_sync_first;
        fb[1] = bad_sync ? cur_sync_second ^ 8'($urandom_range(1, 255)) : cur_sync_second;
        for (i = 2; i < FRAME_BYTES; i++)
        begin
            if (extremes)
                fb[i] = ((i / 2) % 2 == 0) ? 8'hFF : 8'h00;
            else if ($urandom_range(0, 7) == 0)
                fb[i] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            else
                fb[i] = 8'($urandom_range(0, 255));
        end
        sum = rcsfr_pkg::CSUM_INIT;
        for (i = 0; i < FRAME_BYTES; i++)
            sum = sum - fb[i];
        fb[FRAME_BYTES]     = sum[7:0];
        fb[FRAME_BYTES + 1] = sum[15:8];
        if (corrupt)
            fb[FRAME_BYTES + $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
        for (i = 0; i < n_bytes; i++)
        begin
            if (chatter && $urandom_range(0, 9) == 0)
            begin
                if ($urandom_range(0, 1))
                    send_tick();
                else
                    send_read(4'($urandom_range(0, 15)));
            end
            send_byte(fb[i]);
        end
    endtask

    // Stops offering items and waits until every decoded result has been taken, then lets
    // the block settle before it returns.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic put_reg(rcsfr_pkg::cfg_reg_t idx, logic [rcsfr_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Writes all four registers back to back; only called while the block is idle. The
    // unused upper bits of the sync writes carry random values that must be ignored.
    task automatic write_config(logic [7:0] sf, logic [7:0] ss, logic [15:0] dead,
                                logic [15:0] dflt);
        put_reg(rcsfr_pkg::CFG_SYNC_FIRST, {8'($urandom_range(0, 255)), sf});
        put_reg(rcsfr_pkg::CFG_SYNC_SECOND, {8'($urandom_range(0, 255)), ss});
        put_reg(rcsfr_pkg::CFG_DEAD_TIME, dead);
        put_reg(rcsfr_pkg::CFG_DEFAULT_VAL, dflt);
        cfg_we          <= 1'b0;
        cur_sync_first  = sf;
        cur_sync_second = ss;
        cur_dead_time   = dead;
        cur_default     = dflt;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Right after reset the block is in failsafe: reads give the reset default, reads past
    // the last channel give zero, and the unused kind only reports the flag.
    task automatic test_reset_values();
        rcsfr_pkg::in_item_t it;
        send_read(4'd0);
        send_read(4'(NUM_CH - 1));
        send_read(4'(NUM_CH));
        send_read(4'hF);
        it.kind          = rcsfr_pkg::KIND_NONE;
        it.rx_byte       = 8'hFF;
        it.channel_index = 4'hF;
        send_item(it);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_tick();
    endtask

    // A good frame under the reset sync values commits all-zero and all-one channels and
    // leaves failsafe; a frame with a wrong checksum is flagged and commits nothing.
    task automatic test_frame_checksum();
        send_frame(FRAME_BYTES + 2, 1'b0, 1'b1, 1'b0, 1'b0);
        send_read(4'd0);
        send_read(4'd1);
        send_read(4'(NUM_CH - 1));
        send_read(4'(NUM_CH));
        send_frame(FRAME_BYTES + 2, 1'b1, 1'b0, 1'b0, 1'b0);
        send_read(4'd2);
    endtask

    // A repeated first sync byte restarts the match, a wrong second byte drops back to the
    // hunt, and equal sync values still frame correctly.
    task automatic test_sync_rules();
        send_byte(cur_sync_first);
        send_frame(FRAME_BYTES + 2, 1'b0, 1'b0, 1'b0, 1'b0);
        send_frame(FRAME_BYTES + 2, 1'b0, 1'b0, 1'b0, 1'b1);
        send_frame(FRAME_BYTES + 2, 1'b0, 1'b0, 1'b0, 1'b0);
        send_read(4'd3);
        wait_idle();
        write_config(8'hFF, 8'hFF, rcsfr_pkg::DEAD_TIME_RST, rcsfr_pkg::DEFAULT_VAL_RST);
        send_frame(FRAME_BYTES + 2, 1'b0, 1'b0, 1'b0, 1'b0);
        send_read(4'd7);
    endtask

    // With a dead time of one, the second silent tick engages failsafe and reads give
    // the configured default until the next good frame.
    task automatic test_failsafe_timeout();
        wait_idle();
        write_config(8'h20, 8'h40, 16'd1, 16'h0000);
        send_frame(FRAME_BYTES + 2, 1'b0, 1'b0, 1'b0, 1'b0);
        send_tick();
        send_read(4'd0);
        send_tick();
        send_read(4'd0);
        send_frame(FRAME_BYTES + 2, 1'b0, 1'b0, 1'b0, 1'b0);
        send_read(4'd0);
    endtask

    // The silence counter must stop at its maximum: with the dead time one below it, failsafe
    // engages once the counter reaches the maximum and stays set to the end of the run, and a
    // longest dead time then clears it on the next tick. A wrapping counter would drop it before the read.
    task automatic test_silence_saturation();
        wait_idle();
        write_config(8'h20, 8'h40, 16'hFFFE, 16'hFFFF);
        no_idle = 1'b1;
        repeat (SATURATE_TICKS) send_tick();
        send_read(4'd5);
        wait_idle();
        no_idle = 1'b0;
        write_config(8'h20, 8'h40, 16'hFFFF, 16'hFFFF);
        send_tick();
        send_read(4'd5);
    endtask

    // Random traffic of frames, mostly whole ones with random content, mixed with tick bursts,
    // reads, stray bytes and unused items. Some frames are cut short, carry a bad checksum
    // or a wrong second sync byte.
    task automatic test_random_traffic(int n_items);
        int stop_at;
        int pick;
        int variant;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
            begin
                variant = $urandom_range(0, 19);
                if (variant < 2)
                    send_frame($urandom_range(1, FRAME_BYTES + 1), 1'b0, 1'b0, 1'b1, 1'b0);
                else if (variant == 2)
                    send_frame(FRAME_BYTES + 2, 1'b0, 1'b0, 1'b1, 1'b1);
                else if (variant < 6)
                    send_frame(FRAME_BYTES + 2, 1'b1, 1'b0, 1'b1, 1'b0);
                else
                    send_frame(FRAME_BYTES + 2, 1'b0, variant == 6, 1'b1, 1'b0);
            end
            else if (pick < 45)
            begin
                // Long bursts run past the dead time now and then.
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 64)) send_tick();
                else
                    repeat ($urandom_range(1, 4)) send_tick();
            end
            else if (pick < 80)
            begin
                send_read(4'($urandom_range(0, 15)));
            end
            else if (pick < 95)
            begin
                variant = $urandom_range(0, 3);
                if (variant == 0)
                    send_byte(cur_sync_first);
                else if (variant == 1)
                    send_byte(cur_sync_second);
                else
                    send_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                send_none();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin : stimulus
        int i;
        rst_n         <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.payload <= '0;
        cfg_we        <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;

        // The model starts from the documented reset state.
        cur_sync_first  = rcsfr_pkg::SYNC_FIRST_RST;
        cur_sync_second = rcsfr_pkg::SYNC_SECOND_RST;
        cur_dead_time   = rcsfr_pkg::DEAD_TIME_RST;
        cur_default     = rcsfr_pkg::DEFAULT_VAL_RST;
        restart_hunt();
        csum_lo     = '0;
        quiet_ticks = '0;
        in_failsafe = 1'b1;
        for (i = 0; i < NUM_CH; i++)
        begin
            pend_ch[i] = '0;
            live_ch[i] = rcsfr_pkg::DEFAULT_VAL_RST;
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_reset_values();
        test_frame_checksum();
        test_sync_rules();
        test_failsafe_timeout();
        test_silence_saturation();

        // Each random phase runs under its own register setting, the extremes among them.
        // The last phase runs without idling on either side.
        wait_idle();
        write_config(8'h20, 8'h40, 16'd40, 16'($urandom_range(0, 65535)));
        test_random_traffic(PHASE_ITEMS);
        wait_idle();
        write_config(8'h00, 8'hFF, 16'd1, 16'h0000);
        test_random_traffic(PHASE_ITEMS);
        wait_idle();
        write_config(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
        test_random_traffic(PHASE_ITEMS);
        wait_idle();
        write_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     16'($urandom_range(5, 60)), 16'($urandom_range(0, 65535)));
        no_idle = 1'b1;
        test_random_traffic(PHASE_ITEMS);
        wait_idle();

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
